// ----- rtl/sfdw_pkg.sv -----
// Package with format codes and special result patterns for the small-float widener.
package sfdw_pkg;
  localparam logic [1:0] FMT_S143 = 2'd0;
  localparam logic [1:0] FMT_U44  = 2'd1;
  localparam logic [1:0] FMT_HALF = 2'd2;

  localparam logic [0:0] REG_FORMAT_A = 1'b0;
  localparam logic [0:0] REG_FORMAT_B = 1'b1;

  localparam logic [63:0] POS_NAN = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_NAN = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] POS_INF = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] NEG_INF = 64'hfff0_0000_0000_0000;

  typedef logic [63:0] dbl_t;
endpackage

// ----- rtl/sfdw_conv.sv -----
// Combinational conversion of one small-float code to a double bit pattern.
module sfdw_conv
  import sfdw_pkg::*;
(
  input  logic [1:0]  fmt,
  input  logic [15:0] raw,
  output dbl_t        dbl
);
  logic [3:0]  lz;
  logic [9:0]  mn;
  logic [10:0] ex;
  logic [19:0] fr;

  // Leading-zero count of the 10-bit half mantissa; small formats are left-aligned into it.
  always_comb begin
    lz = 4'd0;
    mn = 10'd0;
    ex = 11'd0;
    fr = 20'd0;
    dbl = 64'd0;
    case (fmt)
      FMT_S143: begin
        if (raw[7:0] == 8'h7f) dbl = POS_NAN;
        else if (raw[7:0] == 8'hff) dbl = NEG_NAN;
        else if (raw[6:0] == 7'd0) dbl = {raw[7], 63'd0};
        else if (raw[6:3] != 4'd0) begin
          ex  = 11'd1016 + {7'd0, raw[6:3]};
          dbl = {raw[7], ex, raw[2:0], 49'd0};
        end else begin
          if (raw[2]) lz = 4'd0; else if (raw[1]) lz = 4'd1; else lz = 4'd2;
          mn  = {raw[2:0], 7'd0} << (lz + 4'd1);
          ex  = 11'd1016 - {7'd0, lz};
          dbl = {raw[7], ex, mn[9:7], 49'd0};
        end
      end
      FMT_U44: begin
        if (raw[7:0] == 8'hff) dbl = POS_NAN;
        else if (raw[7:0] == 8'h00) dbl = 64'd0;
        else if (raw[7:4] != 4'd0) begin
          ex  = 11'd1016 + {7'd0, raw[7:4]};
          dbl = {1'b0, ex, raw[3:0], 48'd0};
        end else begin
          if (raw[3]) lz = 4'd0; else if (raw[2]) lz = 4'd1;
          else if (raw[1]) lz = 4'd2; else lz = 4'd3;
          mn  = {raw[3:0], 6'd0} << (lz + 4'd1);
          ex  = 11'd1016 - {7'd0, lz};
          dbl = {1'b0, ex, mn[9:6], 48'd0};
        end
      end
      FMT_HALF: begin
        if (raw[14:10] == 5'd31) begin
          if (raw[9:0] == 10'd0) dbl = raw[15] ? NEG_INF : POS_INF;
          else dbl = raw[15] ? NEG_NAN : POS_NAN;
        end else if (raw[14:0] == 15'd0) dbl = {raw[15], 63'd0};
        else if (raw[14:10] != 5'd0) begin
          ex  = 11'd1008 + {6'd0, raw[14:10]};
          dbl = {raw[15], ex, raw[9:0], 42'd0};
        end else begin
          for (int i = 0; i < 10; i++) if (raw[i]) lz = 4'(9 - i);
          mn  = raw[9:0] << (lz + 4'd1);
          fr  = {mn, 10'd0};
          ex  = 11'd1008 - {7'd0, lz};
          dbl = {raw[15], ex, fr, 32'd0};
        end
      end
      default: dbl = 64'd0;
    endcase
  end
endmodule

// ----- rtl/small_float_to_double_widener.sv -----
// Top level of the small-float to double widener: stream ports, format registers, output stage.
//
// Each input item carries a raw small-float code and a selector that picks configured
// format A or B (signed 1.4.3, unsigned 4.4 or IEEE half); the result item is the exact
// IEEE double bit pattern. Conversion is one pass of combinational logic into the output
// register; an item is accepted when that register can take it and its result appears in
// the cycle after, one item per cycle at most. Format registers are written through the
// cfg port; the user must do so only while the block is idle, which it does not enforce.
module small_float_to_double_widener
  import sfdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // raw_value[15:0]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // double_bits[63:0]
);
  logic [1:0] fmt_a_r, fmt_b_r, fmt_sel;
  logic       vld_r;
  dbl_t       dat_r, conv;

  // The output register refills whenever it is empty or being drained.
  assign in_tready  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;
  assign fmt_sel    = in_tuser ? fmt_b_r : fmt_a_r;

  sfdw_conv u_conv (.fmt(fmt_sel), .raw(in_tdata), .dbl(conv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_a_r <= FMT_S143;
      fmt_b_r <= FMT_S143;
      vld_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_FORMAT_A) fmt_a_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_FORMAT_B) fmt_b_r <= cfg_wdata;
      if (in_tready) vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) dat_r <= conv;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid) else $error("fill");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
endmodule
